// File: rtl/core/radar_frame_parser_top_macros.svh
// ----------------------------------------------------------------------------
// radar_frame_parser_top_macros
// Assertion helpers shared by the frame parser RTL.
// Each macro expands to one labeled concurrent assertion, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RADAR_FRAME_PARSER_TOP_MACROS_SVH
`define RADAR_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication
`define RFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared constants, codes and types of the radar frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rfp_pkg;

    // Largest payload a frame may announce
    localparam int MAX_PAYLOAD = 256;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEART_CTRL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_CTRL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_CTRL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CMD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_CMD  = 3'd4;

    // Frame delimiters
    localparam logic [7:0] SYNC_A = 8'h53;
    localparam logic [7:0] SYNC_B = 8'h59;
    localparam logic [7:0] END_A  = 8'h54;
    localparam logic [7:0] END_B  = 8'h43;

    // Per-byte status codes
    localparam logic [2:0] ST_MORE    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_HDR_ERR = 3'd2;
    localparam logic [2:0] ST_LEN_ERR = 3'd3;
    localparam logic [2:0] ST_SUM_ERR = 3'd4;
    localparam logic [2:0] ST_END_ERR = 3'd5;

    // Events from the parser to the statistics block
    typedef struct packed {
        logic             good;
        logic             fmt_err;
        logic             sum_err;
        logic [7:0]       control;
        logic [7:0]       command;
        logic [LEN_W-1:0] length;
        logic [7:0]       first_byte;
    } t_frame_evt;

endpackage

`default_nettype wire

// File: rtl/core/rfp_parser.sv
// ----------------------------------------------------------------------------
// rfp_parser
// Byte-serial frame state machine with running 8-bit sum checksum.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radar_frame_parser_top_macros.svh"

module rfp_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_acc,
    input  wire logic [7:0]        i_rx_byte,
    output logic [2:0]             o_status,
    output rfp_pkg::t_frame_evt    o_evt
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_HEAD2 = 4'd1;
    localparam logic [3:0] PH_CTRL  = 4'd2;
    localparam logic [3:0] PH_CMD   = 4'd3;
    localparam logic [3:0] PH_LENH  = 4'd4;
    localparam logic [3:0] PH_LENL  = 4'd5;
    localparam logic [3:0] PH_DATA  = 4'd6;
    localparam logic [3:0] PH_SUM   = 4'd7;
    localparam logic [3:0] PH_TAIL1 = 4'd8;
    localparam logic [3:0] PH_TAIL2 = 4'd9;

    logic [3:0]                r_phase,     n_phase;
    logic [7:0]                r_sum,       n_sum;
    logic [7:0]                r_control,   n_control;
    logic [7:0]                r_command,   n_command;
    logic [7:0]                r_len_hi,    n_len_hi;
    logic [rfp_pkg::LEN_W-1:0] r_frame_len, n_frame_len;
    logic [rfp_pkg::LEN_W-1:0] r_pos,       n_pos;
    logic [7:0]                r_first,     n_first;
    logic [15:0]               w_len_full;

    assign w_len_full = {r_len_hi, i_rx_byte};

    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_control   = r_control;
        n_command   = r_command;
        n_len_hi    = r_len_hi;
        n_frame_len = r_frame_len;
        n_pos       = r_pos;
        n_first     = r_first;
        o_status    = rfp_pkg::ST_MORE;
        o_evt            = '0;
        o_evt.control    = r_control;
        o_evt.command    = r_command;
        o_evt.length     = r_frame_len;
        o_evt.first_byte = r_first;

        case (r_phase)
            PH_HEAD2: begin
                if (i_rx_byte == rfp_pkg::SYNC_B) begin
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = PH_CTRL;
                end else begin
                    o_evt.fmt_err = 1'b1;
                    o_status      = rfp_pkg::ST_HDR_ERR;
                    n_phase       = PH_IDLE;
                end
            end
            PH_CTRL: begin
                n_sum     = r_sum + i_rx_byte;
                n_control = i_rx_byte;
                n_phase   = PH_CMD;
            end
            PH_CMD: begin
                n_sum     = r_sum + i_rx_byte;
                n_command = i_rx_byte;
                n_phase   = PH_LENH;
            end
            PH_LENH: begin
                n_sum    = r_sum + i_rx_byte;
                n_len_hi = i_rx_byte;
                n_phase  = PH_LENL;
            end
            PH_LENL: begin
                n_sum = r_sum + i_rx_byte;
                if (w_len_full > 16'(rfp_pkg::MAX_PAYLOAD)) begin
                    o_evt.fmt_err = 1'b1;
                    o_status      = rfp_pkg::ST_LEN_ERR;
                    n_phase       = PH_IDLE;
                end else begin
                    n_frame_len = w_len_full[rfp_pkg::LEN_W-1:0];
                    n_phase     = (w_len_full == 16'd0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                n_sum = r_sum + i_rx_byte;
                if (r_pos == '0) begin
                    n_first = i_rx_byte;
                end
                // pos stays below length here, so the increment cannot wrap
                n_pos = r_pos + 1'b1;
                if (n_pos >= r_frame_len) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                if (r_sum != i_rx_byte) begin
                    o_evt.sum_err = 1'b1;
                    o_status      = rfp_pkg::ST_SUM_ERR;
                    n_phase       = PH_IDLE;
                end else begin
                    n_phase = PH_TAIL1;
                end
            end
            PH_TAIL1: begin
                if (i_rx_byte == rfp_pkg::END_A) begin
                    n_phase = PH_TAIL2;
                end else begin
                    o_evt.fmt_err = 1'b1;
                    o_status      = rfp_pkg::ST_END_ERR;
                    n_phase       = PH_IDLE;
                end
            end
            PH_TAIL2: begin
                if (i_rx_byte == rfp_pkg::END_B) begin
                    o_evt.good = 1'b1;
                    o_status   = rfp_pkg::ST_OK;
                end else begin
                    o_evt.fmt_err = 1'b1;
                    o_status      = rfp_pkg::ST_END_ERR;
                end
                n_phase = PH_IDLE;
            end
            default: begin
                // idle and unused codes hunt for the first sync byte
                if (i_rx_byte == rfp_pkg::SYNC_A) begin
                    n_sum   = i_rx_byte;
                    n_pos   = '0;
                    n_phase = PH_HEAD2;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_acc) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_sum       <= n_sum;
            r_control   <= n_control;
            r_command   <= n_command;
            r_len_hi    <= n_len_hi;
            r_frame_len <= n_frame_len;
            r_pos       <= n_pos;
            r_first     <= n_first;
        end
    end

    `RFP_ASSERT_NOW(a_sum_pos_done, i_clk, i_rst_n, r_phase == PH_SUM,
        r_pos == r_frame_len, "checksum phase reached with payload count short")
    `RFP_ASSERT_NOW(a_data_pos_bound, i_clk, i_rst_n, r_phase == PH_DATA,
        r_pos < r_frame_len, "payload count ran past frame length")
    `RFP_ASSERT_NEXT(a_good_from_tail, i_clk, i_rst_n, i_acc && o_evt.good,
        r_phase == PH_IDLE, "parser did not return to idle after a good frame")

endmodule

`default_nettype wire

// File: rtl/core/rfp_stats.sv
// ----------------------------------------------------------------------------
// rfp_stats
// Code registers, saturating frame/error counters and latched report values.
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_stats (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr,
    input  wire logic [rfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data,
    input  wire logic                          i_acc,
    input  rfp_pkg::t_frame_evt                i_evt,
    output logic signed [8:0]                  o_heart_rate,
    output logic signed [8:0]                  o_breath_rate,
    output logic signed [8:0]                  o_motion_level,
    output logic [rfp_pkg::CNT_W-1:0]          o_good_frames,
    output logic [rfp_pkg::CNT_W-1:0]          o_format_errors,
    output logic [rfp_pkg::CNT_W-1:0]          o_sum_errors,
    output logic [7:0]                         o_last_control,
    output logic [7:0]                         o_last_command,
    output logic [15:0]                        o_last_length
);

    logic [7:0] r_heart_ctrl, r_breath_ctrl, r_motion_ctrl, r_rate_cmd, r_motion_cmd;

    logic signed [8:0]         r_heart,  n_heart;
    logic signed [8:0]         r_breath, n_breath;
    logic signed [8:0]         r_motion, n_motion;
    logic [rfp_pkg::CNT_W-1:0] r_good,   n_good;
    logic [rfp_pkg::CNT_W-1:0] r_fmt,    n_fmt;
    logic [rfp_pkg::CNT_W-1:0] r_sumerr, n_sumerr;
    logic [7:0]                r_last_ctrl, n_last_ctrl;
    logic [7:0]                r_last_cmd,  n_last_cmd;
    logic [rfp_pkg::LEN_W-1:0] r_last_len,  n_last_len;
    logic signed [8:0]         w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heart_ctrl  <= '0;
            r_breath_ctrl <= '0;
            r_motion_ctrl <= '0;
            r_rate_cmd    <= '0;
            r_motion_cmd  <= '0;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                rfp_pkg::CFG_HEART_CTRL:  r_heart_ctrl  <= i_cfg_data;
                rfp_pkg::CFG_BREATH_CTRL: r_breath_ctrl <= i_cfg_data;
                rfp_pkg::CFG_MOTION_CTRL: r_motion_ctrl <= i_cfg_data;
                rfp_pkg::CFG_RATE_CMD:    r_rate_cmd    <= i_cfg_data;
                rfp_pkg::CFG_MOTION_CMD:  r_motion_cmd  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_value = $signed({1'b0, i_evt.first_byte});

    always_comb begin
        n_heart     = r_heart;
        n_breath    = r_breath;
        n_motion    = r_motion;
        n_good      = r_good;
        n_fmt       = r_fmt;
        n_sumerr    = r_sumerr;
        n_last_ctrl = r_last_ctrl;
        n_last_cmd  = r_last_cmd;
        n_last_len  = r_last_len;

        if (i_evt.fmt_err && r_fmt != rfp_pkg::CNT_MAX) begin
            n_fmt = r_fmt + 1'b1;
        end
        if (i_evt.sum_err && r_sumerr != rfp_pkg::CNT_MAX) begin
            n_sumerr = r_sumerr + 1'b1;
        end
        if (i_evt.good) begin
            if (r_good != rfp_pkg::CNT_MAX) begin
                n_good = r_good + 1'b1;
            end
            n_last_ctrl = i_evt.control;
            n_last_cmd  = i_evt.command;
            n_last_len  = i_evt.length;
            // first match wins when codes coincide
            if (i_evt.length != '0) begin
                if (i_evt.control == r_heart_ctrl && i_evt.command == r_rate_cmd) begin
                    n_heart = w_value;
                end else if (i_evt.control == r_breath_ctrl
                             && i_evt.command == r_rate_cmd) begin
                    n_breath = w_value;
                end else if (i_evt.control == r_motion_ctrl
                             && i_evt.command == r_motion_cmd) begin
                    n_motion = w_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heart     <= '1;
            r_breath    <= '1;
            r_motion    <= '1;
            r_good      <= '0;
            r_fmt       <= '0;
            r_sumerr    <= '0;
            r_last_ctrl <= '0;
            r_last_cmd  <= '0;
            r_last_len  <= '0;
        end else if (i_acc) begin
            r_heart     <= n_heart;
            r_breath    <= n_breath;
            r_motion    <= n_motion;
            r_good      <= n_good;
            r_fmt       <= n_fmt;
            r_sumerr    <= n_sumerr;
            r_last_ctrl <= n_last_ctrl;
            r_last_cmd  <= n_last_cmd;
            r_last_len  <= n_last_len;
        end
    end

    assign o_heart_rate    = r_heart;
    assign o_breath_rate   = r_breath;
    assign o_motion_level  = r_motion;
    assign o_good_frames   = r_good;
    assign o_format_errors = r_fmt;
    assign o_sum_errors    = r_sumerr;
    assign o_last_control  = r_last_ctrl;
    assign o_last_command  = r_last_cmd;
    assign o_last_length   = 16'(r_last_len);

endmodule

`default_nettype wire

// File: rtl/core/radar_frame_parser_top.sv
// ----------------------------------------------------------------------------
// radar_frame_parser_top
// Byte-stream parser for sync/control/command/length/payload/sum/tail frames.
// ----------------------------------------------------------------------------
// One received byte is taken per request and one status result is returned
// for it in the cycle after acceptance. The block accepts a byte every cycle:
// the whole per-byte step (phase update, running checksum, counter bump) is
// one pass through the parser state machine into the state and result
// registers, so throughput is one byte per clock as long as the result side
// is not stalled. Counters and latched report values are shown with every
// result; they reflect the byte that produced that result. Code registers are
// written through the config port, which is always ready.
`default_nettype none

`include "radar_frame_parser_top_macros.svh"

module radar_frame_parser_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data,
    // byte input
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_rx_byte,
    // result output
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [2:0]                         o_status,
    output logic signed [8:0]                  o_heart_rate,
    output logic signed [8:0]                  o_breath_rate,
    output logic signed [8:0]                  o_motion_level,
    output logic [rfp_pkg::CNT_W-1:0]          o_good_frames,
    output logic [rfp_pkg::CNT_W-1:0]          o_format_errors,
    output logic [rfp_pkg::CNT_W-1:0]          o_sum_errors,
    output logic [7:0]                         o_last_control,
    output logic [7:0]                         o_last_command,
    output logic [15:0]                        o_last_length
);

    logic                r_out_vld;
    logic [2:0]          r_status;
    logic [2:0]          w_status;
    logic                w_in_acc;
    rfp_pkg::t_frame_evt w_evt;

    assign o_cfg_ready = 1'b1;
    // a pending result only blocks input while it is being held back
    assign o_in_stall  = r_out_vld && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    rfp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (w_in_acc),
        .i_rx_byte (i_rx_byte),
        .o_status  (w_status),
        .o_evt     (w_evt)
    );

    rfp_stats u_stats (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_acc           (w_in_acc),
        .i_evt           (w_evt),
        .o_heart_rate    (o_heart_rate),
        .o_breath_rate   (o_breath_rate),
        .o_motion_level  (o_motion_level),
        .o_good_frames   (o_good_frames),
        .o_format_errors (o_format_errors),
        .o_sum_errors    (o_sum_errors),
        .o_last_control  (o_last_control),
        .o_last_command  (o_last_command),
        .o_last_length   (o_last_length)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_status <= w_status;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;

    `RFP_ASSERT_NEXT(a_good_counts, i_clk, i_rst_n, w_in_acc && w_evt.good,
        o_good_frames != $past(o_good_frames) || o_good_frames == rfp_pkg::CNT_MAX,
        "good frame not counted")
    `RFP_ASSERT_NOW(a_hdr_err_counted, i_clk, i_rst_n,
        o_out_valid && o_status == rfp_pkg::ST_HDR_ERR,
        o_format_errors != '0, "header error shown with zero format count")
    `RFP_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_in_acc,
        o_out_valid && o_status == $past(w_status), "accepted byte left no result")

endmodule

`default_nettype wire

// File: verif/tb_radar_frame_parser_top.sv
// ----------------------------------------------------------------------------
// tb_radar_frame_parser_top
// Self-checking bench for the byte-serial radar frame parser.
// A local parser model predicts the per-byte report (status, latched rates,
// counters, last frame fields) for every accepted byte. Each report that
// leaves the block is compared with the oldest prediction. Traffic is a mix
// of well-formed frames and broken ones (header, length, checksum, tail),
// sent under several code settings, with bursty input and random stalls.
// ----------------------------------------------------------------------------

module tb_radar_frame_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned PHASE_BYTES   = 250;
    localparam int unsigned NUM_SETTINGS  = 6;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HEAD2, PH_CTRL, PH_CMD, PH_LENH,
        PH_LENL, PH_DATA, PH_SUM, PH_TAIL1, PH_TAIL2
    } t_parse_phase;

    typedef enum int {
        FRAME_OK, BAD_HEADER, BAD_LENGTH, BAD_SUM, BAD_TAIL1, BAD_TAIL2
    } t_frame_fault;

    typedef enum int {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
    } t_stall_style;

    typedef struct packed {
        logic [2:0]        status;
        logic signed [8:0] heart;
        logic signed [8:0] breath;
        logic signed [8:0] motion;
        logic [31:0]       good;
        logic [31:0]       fmt_errs;
        logic [31:0]       sum_errs;
        logic [7:0]        control;
        logic [7:0]        command;
        logic [15:0]       length;
    } t_byte_report;

    // DUT connections
    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          cfg_valid;
    logic                          o_cfg_ready;
    logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                    cfg_data;
    logic                          in_valid;
    logic                          o_in_stall;
    logic [7:0]                    rx_byte;
    logic                          o_out_valid;
    logic                          out_stall = 1'b0;
    logic [2:0]                    o_status;
    logic signed [8:0]             o_heart_rate;
    logic signed [8:0]             o_breath_rate;
    logic signed [8:0]             o_motion_level;
    logic [rfp_pkg::CNT_W-1:0]     o_good_frames;
    logic [rfp_pkg::CNT_W-1:0]     o_format_errors;
    logic [rfp_pkg::CNT_W-1:0]     o_sum_errors;
    logic [7:0]                    o_last_control;
    logic [7:0]                    o_last_command;
    logic [15:0]                   o_last_length;

    radar_frame_parser_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_status        (o_status),
        .o_heart_rate    (o_heart_rate),
        .o_breath_rate   (o_breath_rate),
        .o_motion_level  (o_motion_level),
        .o_good_frames   (o_good_frames),
        .o_format_errors (o_format_errors),
        .o_sum_errors    (o_sum_errors),
        .o_last_control  (o_last_control),
        .o_last_command  (o_last_command),
        .o_last_length   (o_last_length)
    );

    always #4 i_clk = ~i_clk;

    // Parser model state
    t_parse_phase      parse_ph;
    logic [15:0]       payload_idx;
    logic [15:0]       frame_len;
    logic [7:0]        run_sum;
    logic [7:0]        frame_ctrl;
    logic [7:0]        frame_cmd;
    logic [7:0]        first_data;
    logic signed [8:0] heart_val;
    logic signed [8:0] breath_val;
    logic signed [8:0] motion_val;
    logic [31:0]       good_cnt;
    logic [31:0]       fmt_cnt;
    logic [31:0]       sum_cnt;
    logic [7:0]        commit_ctrl;
    logic [7:0]        commit_cmd;
    logic [15:0]       commit_len;
    logic [7:0]        heart_code;
    logic [7:0]        breath_code;
    logic [7:0]        motion_code;
    logic [7:0]        rate_cmd_code;
    logic [7:0]        motion_cmd_code;

    t_byte_report byte_reports_q[$];
    t_byte_report want;

    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned bytes_sent    = 0;
    int unsigned frames_sent   = 0;
    int unsigned settings_used = 0;
    int unsigned burst_left    = 0;
    int unsigned gap_max       = 0;
    int unsigned hold_requests = 0;

    // Receiver-side stall state, owned by the stall process
    int unsigned  hold_seen = 0;
    int unsigned  hold_left = 0;
    int unsigned  mode_left = 0;
    t_stall_style stall_mode = STALL_NONE;

    function automatic logic [31:0] sat_bump(logic [31:0] v);
        return (v == rfp_pkg::CNT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic void reset_model();
        parse_ph    = PH_IDLE;
        payload_idx = '0;
        frame_len   = '0;
        run_sum     = '0;
        frame_ctrl  = '0;
        frame_cmd   = '0;
        first_data  = '0;
        heart_val   = -9'sd1;
        breath_val  = -9'sd1;
        motion_val  = -9'sd1;
        good_cnt    = '0;
        fmt_cnt     = '0;
        sum_cnt     = '0;
        commit_ctrl = '0;
        commit_cmd  = '0;
        commit_len  = '0;
        heart_code      = '0;
        breath_code     = '0;
        motion_code     = '0;
        rate_cmd_code   = '0;
        motion_cmd_code = '0;
    endfunction

    function automatic void apply_reg_write(logic [rfp_pkg::CFG_IDX_W-1:0] idx,
                                            logic [7:0] d);
        case (idx)
            rfp_pkg::CFG_HEART_CTRL:  heart_code      = d;
            rfp_pkg::CFG_BREATH_CTRL: breath_code     = d;
            rfp_pkg::CFG_MOTION_CTRL: motion_code     = d;
            rfp_pkg::CFG_RATE_CMD:    rate_cmd_code   = d;
            rfp_pkg::CFG_MOTION_CMD:  motion_cmd_code = d;
            default: ;
        endcase
    endfunction

    function automatic void record_good_frame();
        good_cnt    = sat_bump(good_cnt);
        commit_ctrl = frame_ctrl;
        commit_cmd  = frame_cmd;
        commit_len  = frame_len;
        // first match wins when codes coincide
        if (frame_len >= 16'd1) begin
            if (frame_ctrl == heart_code && frame_cmd == rate_cmd_code)
                heart_val = $signed({1'b0, first_data});
            else if (frame_ctrl == breath_code && frame_cmd == rate_cmd_code)
                breath_val = $signed({1'b0, first_data});
            else if (frame_ctrl == motion_code && frame_cmd == motion_cmd_code)
                motion_val = $signed({1'b0, first_data});
        end
    endfunction

    function automatic t_byte_report parse_byte(logic [7:0] b);
        t_byte_report r;
        logic [2:0]   st;
        st = rfp_pkg::ST_MORE;
        case (parse_ph)
            PH_HEAD2: begin
                if (b == rfp_pkg::SYNC_B) begin
                    run_sum  = run_sum + b;
                    parse_ph = PH_CTRL;
                end else begin
                    // the offending byte is not rechecked as a new sync
                    fmt_cnt  = sat_bump(fmt_cnt);
                    parse_ph = PH_IDLE;
                    st       = rfp_pkg::ST_HDR_ERR;
                end
            end
            PH_CTRL: begin
                run_sum    = run_sum + b;
                frame_ctrl = b;
                parse_ph   = PH_CMD;
            end
            PH_CMD: begin
                run_sum   = run_sum + b;
                frame_cmd = b;
                parse_ph  = PH_LENH;
            end
            PH_LENH: begin
                run_sum   = run_sum + b;
                frame_len = {b, 8'h00};
                parse_ph  = PH_LENL;
            end
            PH_LENL: begin
                run_sum   = run_sum + b;
                frame_len = {frame_len[15:8], b};
                if (int'(frame_len) > rfp_pkg::MAX_PAYLOAD) begin
                    fmt_cnt  = sat_bump(fmt_cnt);
                    parse_ph = PH_IDLE;
                    st       = rfp_pkg::ST_LEN_ERR;
                end else begin
                    parse_ph = (frame_len == 16'd0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                run_sum = run_sum + b;
                if (payload_idx == 16'd0)
                    first_data = b;
                if (payload_idx != 16'hFFFF)
                    payload_idx = payload_idx + 16'd1;
                if (payload_idx >= frame_len)
                    parse_ph = PH_SUM;
            end
            PH_SUM: begin
                if (run_sum != b) begin
                    sum_cnt  = sat_bump(sum_cnt);
                    parse_ph = PH_IDLE;
                    st       = rfp_pkg::ST_SUM_ERR;
                end else begin
                    parse_ph = PH_TAIL1;
                end
            end
            PH_TAIL1: begin
                if (b == rfp_pkg::END_A) begin
                    parse_ph = PH_TAIL2;
                end else begin
                    fmt_cnt  = sat_bump(fmt_cnt);
                    parse_ph = PH_IDLE;
                    st       = rfp_pkg::ST_END_ERR;
                end
            end
            PH_TAIL2: begin
                if (b == rfp_pkg::END_B) begin
                    record_good_frame();
                    st = rfp_pkg::ST_OK;
                end else begin
                    fmt_cnt = sat_bump(fmt_cnt);
                    st      = rfp_pkg::ST_END_ERR;
                end
                parse_ph = PH_IDLE;
            end
            default: begin
                if (b == rfp_pkg::SYNC_A) begin
                    run_sum     = b;
                    payload_idx = '0;
                    parse_ph    = PH_HEAD2;
                end else begin
                    parse_ph = PH_IDLE;
                end
            end
        endcase
        r.status   = st;
        r.heart    = heart_val;
        r.breath   = breath_val;
        r.motion   = motion_val;
        r.good     = good_cnt;
        r.fmt_errs = fmt_cnt;
        r.sum_errs = sum_cnt;
        r.control  = commit_ctrl;
        r.command  = commit_cmd;
        r.length   = commit_len;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Predict on each accepted request, check each accepted report
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready)
                apply_reg_write(cfg_index, cfg_data);
            if (in_valid && !o_in_stall)
                byte_reports_q.push_back(parse_byte(rx_byte));
            if (o_out_valid && !out_stall) begin
                if (byte_reports_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: report with no pending byte, expected none actual status %0h",
                             $time, o_status);
                end else begin
                    want = byte_reports_q.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("heart_rate", 32'(want.heart), 32'(o_heart_rate));
                    check_field("breath_rate", 32'(want.breath), 32'(o_breath_rate));
                    check_field("motion_level", 32'(want.motion), 32'(o_motion_level));
                    check_field("good_frames", want.good, o_good_frames);
                    check_field("format_errors", want.fmt_errs, o_format_errors);
                    check_field("sum_errors", want.sum_errs, o_sum_errors);
                    check_field("last_control", 32'(want.control), 32'(o_last_control));
                    check_field("last_command", 32'(want.command), 32'(o_last_command));
                    check_field("last_length", 32'(want.length), 32'(o_last_length));
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            stall_mode = t_stall_style'($urandom_range(0, 3));
            mode_left  = $urandom_range(32, 200);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
                default:     out_stall <= (mode_left % 3 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d reports pending",
                     $time, cycle_count, byte_reports_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // One byte request; bursts of random length separated by random gaps
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (!(in_valid && !o_in_stall));
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] ctrl, input logic [7:0] cmd,
                              input int unsigned len, input t_frame_fault fault);
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] len16;
        len16 = len[15:0];
        frames_sent++;
        send_byte(rfp_pkg::SYNC_A);
        if (fault == BAD_HEADER) begin
            do b = 8'($urandom); while (b == rfp_pkg::SYNC_B);
            send_byte(b);
            return;
        end
        send_byte(rfp_pkg::SYNC_B);
        send_byte(ctrl);
        send_byte(cmd);
        send_byte(len16[15:8]);
        send_byte(len16[7:0]);
        if (fault == BAD_LENGTH)
            return;
        sum = rfp_pkg::SYNC_A + rfp_pkg::SYNC_B + ctrl + cmd + len16[15:8] + len16[7:0];
        for (int unsigned i = 0; i < len; i++) begin
            b   = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        if (fault == BAD_SUM) begin
            send_byte(sum ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(sum);
        if (fault == BAD_TAIL1) begin
            do b = 8'($urandom); while (b == rfp_pkg::END_A);
            send_byte(b);
            return;
        end
        send_byte(rfp_pkg::END_A);
        if (fault == BAD_TAIL2) begin
            do b = 8'($urandom); while (b == rfp_pkg::END_B);
            send_byte(b);
        end else begin
            send_byte(rfp_pkg::END_B);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (byte_reports_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rfp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_codes(input logic [7:0] h, input logic [7:0] br,
                               input logic [7:0] m, input logic [7:0] rc,
                               input logic [7:0] mc);
        wait_drain();
        write_reg(rfp_pkg::CFG_HEART_CTRL, h);
        write_reg(rfp_pkg::CFG_BREATH_CTRL, br);
        write_reg(rfp_pkg::CFG_MOTION_CTRL, m);
        write_reg(rfp_pkg::CFG_RATE_CMD, rc);
        write_reg(rfp_pkg::CFG_MOTION_CMD, mc);
        settings_used++;
    endtask

    function automatic logic [7:0] pick_control();
        case ($urandom_range(0, 4))
            0: return heart_code;
            1: return breath_code;
            2: return motion_code;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 3))
            0: return rate_cmd_code;
            1: return motion_cmd_code;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 4);
        if (r < 90) return $urandom_range(5, 32);
        if (r < 98) return $urandom_range(33, 128);
        return $urandom_range(rfp_pkg::MAX_PAYLOAD - 1, rfp_pkg::MAX_PAYLOAD);
    endfunction

    function automatic int unsigned pick_bad_length();
        case ($urandom_range(0, 3))
            0: return rfp_pkg::MAX_PAYLOAD + 1;
            1: return 32'hFFFF;
            default: return $urandom_range(rfp_pkg::MAX_PAYLOAD + 1, 32'hFFFF);
        endcase
    endfunction

    task automatic send_random_frame();
        int unsigned  r;
        t_frame_fault fault;
        r = $urandom_range(0, 99);
        if (r < 70)      fault = FRAME_OK;
        else if (r < 76) fault = BAD_HEADER;
        else if (r < 82) fault = BAD_LENGTH;
        else if (r < 88) fault = BAD_SUM;
        else if (r < 94) fault = BAD_TAIL1;
        else             fault = BAD_TAIL2;
        send_frame(pick_control(), pick_command(),
                   (fault == BAD_LENGTH) ? pick_bad_length() : pick_length(), fault);
    endtask

    // Idle drops, bad second header byte that is itself a sync byte
    task automatic test_idle_and_header();
        gap_max = 3;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(rfp_pkg::SYNC_B);
        send_byte(rfp_pkg::SYNC_A);
        send_byte(rfp_pkg::SYNC_A);
        send_byte(rfp_pkg::SYNC_B);
        wait_drain();
    endtask

    // Length just over the limit, zero length, one byte with reset codes, full size
    task automatic test_length_bounds();
        send_frame(8'h00, 8'h00, rfp_pkg::MAX_PAYLOAD + 1, BAD_LENGTH);
        send_frame(8'h00, 8'h00, 0, FRAME_OK);
        send_frame(8'h00, 8'h00, 1, FRAME_OK);
        send_frame(8'hFF, 8'hFF, rfp_pkg::MAX_PAYLOAD, FRAME_OK);
        wait_drain();
    endtask

    // Long receiver hold-off while the sender keeps offering back to back
    task automatic test_back_pressure();
        int unsigned start;
        gap_max = 0;
        start   = bytes_sent;
        hold_requests++;
        while (bytes_sent - start < 80)
            send_random_frame();
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        logic [7:0]  c;
        logic [7:0]  k;
        for (int unsigned s = 0; s < NUM_SETTINGS; s++) begin
            c = 8'($urandom);
            k = 8'($urandom);
            case (s)
                0: apply_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                1: apply_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2: apply_codes(c, c + 8'd1, c + 8'd2, k, k + 8'd1);
                // all controls and commands equal: heart always wins
                3: apply_codes(c, c, c, k, k);
                // breath and motion share codes, heart differs
                4: apply_codes(c ^ 8'h80, c, c, k, k);
                default: apply_codes(8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 8'($urandom));
            endcase
            if (s == 2) begin
                // unmapped indexes must leave the codes alone
                for (int unsigned idx = rfp_pkg::CFG_MOTION_CMD + 1;
                     idx < (1 << rfp_pkg::CFG_IDX_W); idx++)
                    write_reg(rfp_pkg::CFG_IDX_W'(idx), 8'($urandom));
            end
            gap_max = (s == 1) ? 0 : $urandom_range(1, 8);
            start   = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) begin
                if ($urandom_range(0, 9) == 0) begin
                    // a little line noise between frames
                    repeat ($urandom_range(1, 3)) begin
                        send_byte(8'($urandom));
                        bytes_sent--;
                    end
                end
                send_random_frame();
            end
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_header();
        test_length_bounds();
        test_back_pressure();
        test_random_traffic();

        wait_drain();
        $display("Sent %0d frame bytes in %0d frames under %0d code settings,", bytes_sent,
                 frames_sent, settings_used);
        $display("seeing %0d good frames, %0d format errors and %0d checksum errors.",
                 good_cnt, fmt_cnt, sum_cnt);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
